// ===== hw/rtl/fpsl_pkg.sv =====
// Constants, widths and register codes shared by the filtered PI speed loop.
package fpsl_pkg;

   localparam int FRACTION_BITS = 8;
   localparam int GAIN_FRACTION = 8;

   localparam int COUNT_W = 16;
   localparam int TILT_W = 13;
   localparam int GAIN_W = 16;
   localparam int DRIVE_W = 16;

   localparam int ERR_W = COUNT_W + 2;
   localparam int FILT_W = ERR_W + FRACTION_BITS;
   localparam int ACC_W = FILT_W + 2;

   localparam int INTEGRAL_LIMIT = 12000;
   localparam int INT_W = $clog2(INTEGRAL_LIMIT * (2 ** FRACTION_BITS) + 1) + 1;
   localparam int ISUM_W = ((FILT_W > INT_W) ? FILT_W : INT_W) + 1;

   localparam int PROD_P_W = GAIN_W + FILT_W;
   localparam int PROD_I_W = GAIN_W + INT_W;
   localparam int SUM_W = ((PROD_P_W > PROD_I_W) ? PROD_P_W : PROD_I_W) + 1;
   localparam int DRIVE_SHIFT = FRACTION_BITS + GAIN_FRACTION;
   localparam int DRV_FULL_W = SUM_W - DRIVE_SHIFT;

   localparam int DRIVE_MAX = 32767;
   localparam int DRIVE_MIN = -32768;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] REG_PROP_GAIN = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] REG_INTEGRAL_GAIN = CSR_ADDR_W'(1);
   localparam logic [CSR_ADDR_W-1:0] REG_TILT_LOW = CSR_ADDR_W'(2);
   localparam logic [CSR_ADDR_W-1:0] REG_TILT_HIGH = CSR_ADDR_W'(3);

   localparam logic signed [TILT_W-1:0] TILT_LOW_RESET = TILT_W'(320);
   localparam logic signed [TILT_W-1:0] TILT_HIGH_RESET = TILT_W'(1248);

endpackage

// ===== hw/rtl/fpsl_req_if.sv =====
// Input channel interface carrying one speed loop sample word.
interface fpsl_req_if;
   import fpsl_pkg::*;

   logic valid;
   logic ready;
   logic signed [COUNT_W-1:0] left_count;
   logic signed [COUNT_W-1:0] right_count;
   logic signed [COUNT_W-1:0] target_speed;
   logic signed [TILT_W-1:0] tilt_angle;

   modport source (
      output valid, left_count, right_count, target_speed, tilt_angle,
      input ready
   );
   modport sink (
      input valid, left_count, right_count, target_speed, tilt_angle,
      output ready
   );
endinterface

// ===== hw/rtl/fpsl_rsp_if.sv =====
// Result channel interface carrying one drive word.
interface fpsl_rsp_if;
   import fpsl_pkg::*;

   logic valid;
   logic ready;
   logic signed [DRIVE_W-1:0] drive;
   logic saturated;

   modport source (output valid, drive, saturated, input ready);
   modport sink (input valid, drive, saturated, output ready);
endinterface

// ===== hw/rtl/fpsl_csr_if.sv =====
// Configuration write channel interface.
interface fpsl_csr_if;
   import fpsl_pkg::*;

   logic valid;
   logic ready;
   logic [CSR_ADDR_W-1:0] index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/filtered_pi_speed_loop.sv =====
// Filtered PI speed loop with integral clamp and tilt-window integral reset.
//
//   channel    role     contents
//   req_chan   in       left_count, right_count, target_speed, tilt_angle
//   rsp_chan   out      drive, saturated
//   csr_chan   in       register index, write data (ready outside reset)
//
// One word is accepted per cycle while a stalled result does not hold the pipeline.
// The filter and integral recursion closes through one register after the input register;
// the two gain products and the final sum follow in two further stages.
// Reset clears the filter, the integral, the pipeline and the registers to their defaults.
// A stalled result holds the output register, and the stages behind it fill before
// req_chan.ready drops.
module filtered_pi_speed_loop (
   input  logic       clock,
   input  logic       reset,
   fpsl_req_if.sink   req_chan,
   fpsl_rsp_if.source rsp_chan,
   fpsl_csr_if.sink   csr_chan
);
   import fpsl_pkg::*;

   logic signed [GAIN_W-1:0] prop_gain_ff;
   logic signed [GAIN_W-1:0] integral_gain_ff;
   logic signed [TILT_W-1:0] tilt_low_ff;
   logic signed [TILT_W-1:0] tilt_high_ff;

   logic signed [FILT_W-1:0] filt_ff;
   logic signed [INT_W-1:0] integ_ff;

   logic s0_valid_ff;
   logic signed [COUNT_W-1:0] left_ff;
   logic signed [COUNT_W-1:0] right_ff;
   logic signed [COUNT_W-1:0] target_ff;
   logic signed [TILT_W-1:0] tilt_ff;

   logic s1_valid_ff;
   logic signed [FILT_W-1:0] s1_filt_ff;
   logic signed [INT_W-1:0] s1_integ_ff;

   logic s2_valid_ff;
   logic signed [PROD_P_W-1:0] prod_p_ff;
   logic signed [PROD_I_W-1:0] prod_i_ff;

   logic out_valid_ff;
   logic signed [DRIVE_W-1:0] drive_ff;
   logic sat_ff;

   logic s3_take;
   logic s2_take;
   logic s1_take;
   logic s0_take;
   logic s0_move;

   logic signed [ERR_W-1:0] err;
   logic signed [ACC_W-1:0] filt_x;
   logic signed [ACC_W-1:0] acc;
   logic signed [FILT_W-1:0] filt_in;
   logic signed [ISUM_W-1:0] isum;
   logic signed [INT_W-1:0] integ_in;
   logic tilt_out;

   logic signed [PROD_P_W-1:0] prod_p_in;
   logic signed [PROD_I_W-1:0] prod_i_in;

   logic signed [SUM_W-1:0] sum;
   logic signed [DRV_FULL_W-1:0] drv_full;
   logic signed [DRIVE_W-1:0] drive_in;
   logic sat_in;

   assign s3_take = !out_valid_ff || rsp_chan.ready;
   assign s2_take = !s2_valid_ff || s3_take;
   assign s1_take = !s1_valid_ff || s2_take;
   assign s0_take = !s0_valid_ff || s1_take;
   assign s0_move = s0_valid_ff && s1_take;

   assign req_chan.ready = s0_take && !reset;
   assign csr_chan.ready = !reset;

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.drive = drive_ff;
   assign rsp_chan.saturated = sat_ff;

   // Filter and clamped integral.
   always_comb begin
      err = ERR_W'(left_ff) + ERR_W'(right_ff) - ERR_W'(target_ff);
      filt_x = ACC_W'(filt_ff);
      acc = (filt_x <<< 1) + filt_x + (ACC_W'(err) <<< FRACTION_BITS);
      filt_in = acc[FILT_W+1:2];
      isum = ISUM_W'(integ_ff) + ISUM_W'(filt_in);
      if (isum > ISUM_W'(INTEGRAL_LIMIT * (2 ** FRACTION_BITS))) begin
         integ_in = INT_W'(INTEGRAL_LIMIT * (2 ** FRACTION_BITS));
      end else if (isum < ISUM_W'(-(INTEGRAL_LIMIT * (2 ** FRACTION_BITS)))) begin
         integ_in = INT_W'(-(INTEGRAL_LIMIT * (2 ** FRACTION_BITS)));
      end else begin
         integ_in = isum[INT_W-1:0];
      end
      tilt_out = (tilt_ff < tilt_low_ff) || (tilt_ff > tilt_high_ff);
   end

   assign prod_p_in = PROD_P_W'(prop_gain_ff) * PROD_P_W'(s1_filt_ff);
   assign prod_i_in = PROD_I_W'(integral_gain_ff) * PROD_I_W'(s1_integ_ff);

   // Integer part by floor, then saturation.
   always_comb begin
      sum = SUM_W'(prod_p_ff) + SUM_W'(prod_i_ff);
      drv_full = sum[SUM_W-1:DRIVE_SHIFT];
      if (drv_full > DRV_FULL_W'(DRIVE_MAX)) begin
         drive_in = DRIVE_W'(DRIVE_MAX);
         sat_in = 1'b1;
      end else if (drv_full < DRV_FULL_W'(DRIVE_MIN)) begin
         drive_in = DRIVE_W'(DRIVE_MIN);
         sat_in = 1'b1;
      end else begin
         drive_in = drv_full[DRIVE_W-1:0];
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff <= '0;
         integral_gain_ff <= '0;
         tilt_low_ff <= TILT_LOW_RESET;
         tilt_high_ff <= TILT_HIGH_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            REG_PROP_GAIN: prop_gain_ff <= csr_chan.data[GAIN_W-1:0];
            REG_INTEGRAL_GAIN: integral_gain_ff <= csr_chan.data[GAIN_W-1:0];
            REG_TILT_LOW: tilt_low_ff <= csr_chan.data[TILT_W-1:0];
            REG_TILT_HIGH: tilt_high_ff <= csr_chan.data[TILT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         filt_ff <= '0;
         integ_ff <= '0;
      end else begin
         if (s0_take) begin
            s0_valid_ff <= req_chan.valid;
         end
         if (s1_take) begin
            s1_valid_ff <= s0_valid_ff;
         end
         if (s2_take) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_take) begin
            out_valid_ff <= s2_valid_ff;
         end
         if (s0_move) begin
            filt_ff <= filt_in;
            integ_ff <= tilt_out ? '0 : integ_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s0_take) begin
         left_ff <= req_chan.left_count;
         right_ff <= req_chan.right_count;
         target_ff <= req_chan.target_speed;
         tilt_ff <= req_chan.tilt_angle;
      end
      if (s1_take) begin
         s1_filt_ff <= filt_in;
         s1_integ_ff <= integ_in;
      end
      if (s2_take) begin
         prod_p_ff <= prod_p_in;
         prod_i_ff <= prod_i_in;
      end
      if (s3_take) begin
         drive_ff <= drive_in;
         sat_ff <= sat_in;
      end
   end

endmodule
